FILE: src/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// shared types and codes for the sorted set insert block
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 3;

    // operation selector on the input side
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_LISTED    = 3'd3,
        STAT_EMPTY     = 3'd4
    } ssi_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LIST,
        S_RESP
    } ssi_state_t;

    typedef struct packed {
        ssi_stat_t               status;
        logic signed [VAL_W-1:0] element;
        logic                    last;
    } ssi_res_t;

endpackage

FILE: src/ssi_obuf.sv
// ----------------------------------------------------------------------------
// ssi_obuf
// one-beat output register between the sequencer and the result stream
// ----------------------------------------------------------------------------
module ssi_obuf
    import ssi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ssi_res_t                push_res,
    output logic                    free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [VAL_W-1:0] m_tdata,  // element
    output logic [STAT_W-1:0]       m_tuser,  // status
    output logic                    m_tlast
);

    logic     valid_reg;
    logic     valid_next;
    ssi_res_t res_reg;

    // a held beat leaving this cycle frees the slot
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.element;
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;

endmodule

FILE: src/sorted_set_insert_core.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_core
// ascending set of signed 32-bit values kept in one synchronous memory
// ----------------------------------------------------------------------------
//  channel   dir  beat                  tdata          tuser       tlast
//  s_*       in   one operation         value [31:0]   operation   -
//  m_*       out  one result            element [31:0] status[2:0] last
//
//  insert: one upward pass over the stored entries, one entry per cycle
//  through the single memory read port; the pass ends early when a duplicate
//  or a full store stops it
//  reset clears the state, entry count, scan index and placed flag; memory contents need no clearing
//  a stalled result side holds the listing in place, the memory output waits
// ----------------------------------------------------------------------------
module sorted_set_insert_core
    import ssi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic signed [VAL_W-1:0] s_tdata,  // value
    input  logic                    s_tuser,  // operation
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [VAL_W-1:0] m_tdata,  // element
    output logic [STAT_W-1:0]       m_tuser,  // status
    output logic                    m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    ssi_state_t state_reg, state_next;

    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           w_reg, w_next;
    logic                    placed_reg, placed_next;
    ssi_stat_t               res_status_reg, res_status_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] carry_reg, carry_next;

    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic signed [VAL_W-1:0] q_reg;

    logic                    mem_re;
    logic [CW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [CW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;

    logic          accept;
    logic [CW-1:0] w_inc;
    logic          at_tail;
    logic          full;
    logic          is_dup;
    logic          key_gt;
    logic          scan_stop;
    logic          scan_wr;
    logic          list_last;

    logic     push;
    ssi_res_t push_res;
    logic     free;

    assign accept    = s_tvalid && s_tready;
    assign w_inc     = w_reg + CW'(1);
    assign at_tail   = (w_reg == cnt_reg);
    assign full      = (cnt_reg == CW'(CAPACITY));
    assign is_dup    = (q_reg == val_reg);
    assign key_gt    = (q_reg > val_reg);
    assign list_last = (w_inc == cnt_reg);

    // early end of the pass: duplicate found, or no room for a smaller value
    assign scan_stop = !at_tail && !placed_reg && (is_dup || (key_gt && full));
    assign scan_wr   = at_tail ? (placed_reg || !full)
                               : (placed_reg || (key_gt && !full));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_INSERT)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_LIST;
                    end
                end
            end
            S_SCAN:
            begin
                if (at_tail || scan_stop)
                begin
                    state_next = S_RESP;
                end
            end
            S_LIST:
            begin
                if (free && list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        s_tready        = (state_reg == S_IDLE);
        cnt_next        = cnt_reg;
        w_next          = w_reg;
        placed_next     = placed_reg;
        res_status_next = res_status_reg;
        val_next        = val_reg;
        carry_next      = carry_reg;
        mem_re          = 1'b0;
        mem_raddr       = w_inc;
        mem_we          = 1'b0;
        mem_waddr       = w_reg;
        mem_wdata       = placed_reg ? carry_reg : val_reg;
        push            = 1'b0;
        push_res        = '{status: STAT_LISTED, element: q_reg, last: list_last};
        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (accept)
                begin
                    val_next    = s_tdata;
                    w_next      = '0;
                    placed_next = 1'b0;
                    mem_re      = (cnt_reg != '0);
                    if (s_tuser == OP_READOUT)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                end
            end
            S_SCAN:
            begin
                mem_we = scan_wr;
                if (at_tail)
                begin
                    res_status_next = scan_wr ? STAT_INSERTED : STAT_FULL;
                    if (scan_wr)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else if (scan_stop)
                begin
                    res_status_next = is_dup ? STAT_DUPLICATE : STAT_FULL;
                end
                else
                begin
                    // displaced entry rides one slot up
                    if (scan_wr)
                    begin
                        carry_next  = q_reg;
                        placed_next = 1'b1;
                    end
                    w_next = w_inc;
                    mem_re = (w_inc < cnt_reg);
                end
            end
            S_LIST:
            begin
                push = free;
                if (free)
                begin
                    w_next = w_inc;
                    mem_re = !list_last;
                end
            end
            S_RESP:
            begin
                push     = free;
                push_res = '{status: res_status_reg, element: '0, last: 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            w_reg      <= '0;
            placed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            w_reg      <= w_next;
            placed_reg <= placed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        val_reg        <= val_next;
        carry_reg      <= carry_next;
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            q_reg <= mem[mem_raddr[AW-1:0]];
        end
    end

    ssi_obuf u_obuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (mem_raddr < cnt_reg))
        else $error("read of an entry at or above the count");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr <= cnt_reg) && (mem_waddr < CW'(CAPACITY)))
        else $error("write beyond the filled region");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("entry count moved by other than one");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> free)
        else $error("result pushed into a held output beat");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for sorted_set_insert_core
// drives insert and readout beats with random gaps on both sides, predicts
// every result from a software copy of the sorted set, and checks each result
// beat field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
    import ssi_pkg::*;

    localparam int STORE_CAP    = CAPACITY_DEF;
    localparam int RANDOM_OPS   = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 4 * STORE_CAP;

    typedef struct {
        logic                    op;
        logic signed [VAL_W-1:0] value;
        bit                      hold;   // wait until every result is back
    } op_beat_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic signed [VAL_W-1:0] s_tdata = '0;
    logic                    s_tuser = OP_INSERT;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic signed [VAL_W-1:0] m_tdata;
    logic [STAT_W-1:0]       m_tuser;
    logic                    m_tlast;

    op_beat_t                ops_due[$];
    ssi_res_t                results_due[$];
    logic signed [VAL_W-1:0] stored_set[$];
    logic signed [VAL_W-1:0] seen_vals[$];
    logic                    in_took = 1'b0;
    int                      mismatches = 0;
    int                      cycle_cnt = 0;
    bit                      quiet;

    sorted_set_insert_core #(
        .CAPACITY (STORE_CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // no idling at all inside this window
    assign quiet = (cycle_cnt >= 1000) && (cycle_cnt < 3000);

    // updates the set copy and queues the results one beat causes
    function automatic void apply_set_op(input logic op, input logic signed [VAL_W-1:0] v);
        int       pos;
        ssi_res_t r;
        pos = 0;
        if (op == OP_INSERT)
        begin
            while (pos < stored_set.size() && stored_set[pos] < v)
                pos++;
            r.element = '0;
            r.last    = 1'b1;
            if (pos < stored_set.size() && stored_set[pos] == v)
                r.status = STAT_DUPLICATE;
            else if (stored_set.size() >= STORE_CAP)
                r.status = STAT_FULL;
            else
            begin
                stored_set.insert(pos, v);
                r.status = STAT_INSERTED;
            end
            results_due.push_back(r);
        end
        else if (stored_set.size() == 0)
        begin
            r.status  = STAT_EMPTY;
            r.element = '0;
            r.last    = 1'b1;
            results_due.push_back(r);
        end
        else
        begin
            for (int k = 0; k < stored_set.size(); k++)
            begin
                r.status  = STAT_LISTED;
                r.element = stored_set[k];
                r.last    = (k == stored_set.size() - 1);
                results_due.push_back(r);
            end
        end
    endfunction

    task automatic flag_result(input string why);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", why);
    endtask

    task automatic queue_op(input logic op, input logic signed [VAL_W-1:0] val, input bit hold);
        op_beat_t b;
        b.op    = op;
        b.value = val;
        b.hold  = hold;
        ops_due.push_back(b);
        if (op == OP_INSERT)
            seen_vals.push_back(val);
    endtask

    // monitor: results first, so a beat accepted on this edge never
    // lines up against a result that belongs to an older beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    flag_result($sformatf("unexpected beat status %0d element %0d last %0b",
                                          m_tuser, m_tdata, m_tlast));
                else
                begin
                    ssi_res_t w;
                    w = results_due.pop_front();
                    if (m_tuser !== w.status || m_tdata !== w.element || m_tlast !== w.last)
                        flag_result($sformatf(
                            "expected status %0d element %0d last %0b, got %0d %0d %0b",
                            w.status, w.element, w.last, m_tuser, m_tdata, m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                apply_set_op(s_tuser, s_tdata);
        end
        in_took <= rst_n && s_tvalid && s_tready;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // driver: a new beat only goes out once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_took)
            begin
                if (ops_due.size() != 0 && (quiet || $urandom_range(99) >= 16) &&
                    !(ops_due[0].hold && results_due.size() != 0))
                begin
                    s_tuser  <= ops_due[0].op;
                    s_tdata  <= ops_due[0].value;
                    s_tvalid <= 1'b1;
                    void'(ops_due.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    initial
    begin
        int                      r;
        logic signed [VAL_W-1:0] v;

        // directed: empty readout, extremes, duplicates, middle inserts
        queue_op(OP_READOUT, $urandom, 1'b0);
        queue_op(OP_INSERT, 32'sd0, 1'b0);
        queue_op(OP_INSERT, 32'sh8000_0000, 1'b0);
        queue_op(OP_INSERT, 32'sh7fff_ffff, 1'b0);
        queue_op(OP_INSERT, -32'sd1, 1'b0);
        queue_op(OP_INSERT, 32'sd1, 1'b0);
        queue_op(OP_INSERT, 32'sd0, 1'b0);
        queue_op(OP_INSERT, 32'sh8000_0000, 1'b0);
        queue_op(OP_INSERT, 32'sh7fff_ffff, 1'b0);
        queue_op(OP_READOUT, $urandom, 1'b0);
        queue_op(OP_INSERT, -32'sd2, 1'b0);
        queue_op(OP_INSERT, 32'sh8000_0001, 1'b0);
        queue_op(OP_INSERT, 32'sh7fff_fffe, 1'b0);
        queue_op(OP_INSERT, 32'sh5555_5555, 1'b0);
        queue_op(OP_INSERT, 32'shaaaa_aaaa, 1'b0);
        queue_op(OP_READOUT, 32'shffff_ffff, 1'b0);

        // random: fills the store, then full drops and duplicates into a full store
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(99) < 12)
                queue_op(OP_READOUT, $urandom, (i == 0) || (i == RANDOM_OPS / 2));
            else
            begin
                if (r < 30)
                    v = seen_vals[$urandom_range(seen_vals.size() - 1)];
                else if (r < 40)
                    v = 32'h8000_0000 + $urandom_range(3);
                else if (r < 50)
                    v = 32'h7fff_ffff - $urandom_range(3);
                else if (r < 70)
                    v = $urandom_range(100) - 50;
                else
                    v = $urandom;
                queue_op(OP_INSERT, v, (i == 0) || (i == RANDOM_OPS / 2));
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (ops_due.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
